FILE: design/matrix3x3_inverse_assert.svh
// assertion macros for the 3x3 inverse block
// the including module must have clk and rst_n in scope
`ifndef MATRIX3X3_INVERSE_ASSERT_SVH
`define MATRIX3X3_INVERSE_ASSERT_SVH

// same-cycle implication
`define MI3_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("matrix3x3_inverse: same-cycle check failed");

// next-cycle implication
`define MI3_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("matrix3x3_inverse: next-cycle check failed");

`endif

FILE: design/mi3_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_pkg
// types, constants and cofactor index table for the 3x3 matrix inverse
// ----------------------------------------------------------------------------
package mi3_pkg;

    typedef logic signed [31:0] entry_t;
    typedef logic signed [63:0] prod_t;
    typedef logic signed [64:0] cof_t;
    typedef logic        [63:0] cmag_t;
    typedef logic signed [97:0] det_t;
    typedef logic        [95:0] dmag_t;
    typedef logic        [62:0] thr_t;
    typedef logic        [32:0] quot_t;

    typedef struct packed {
        logic valid;
        logic sing;
        logic neg;
    } det_info_t;

    localparam thr_t        THR_RESET  = 63'd2814750;
    localparam logic [31:0] Q_ONE      = 32'h0001_0000;
    localparam logic [31:0] SAT_POS    = 32'h7fff_ffff;
    localparam logic [31:0] SAT_NEG    = 32'h8000_0000;
    localparam int          QBITS      = 33;
    localparam int          DIV_STAGES = QBITS + 1;

    // cofactor k = e[a]*e[b] - e[c]*e[d], column-major entry index
    localparam int CF_IDX [9][4] = '{
        '{4, 8, 7, 5},
        '{7, 2, 1, 8},
        '{1, 5, 4, 2},
        '{6, 5, 3, 8},
        '{0, 8, 6, 2},
        '{3, 2, 0, 5},
        '{3, 7, 6, 4},
        '{6, 1, 0, 7},
        '{0, 4, 3, 1}
    };

endpackage

FILE: design/matrix3x3_inverse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix3x3_inverse
// 3x3 q16.16 matrix inverse by adjugate over exact determinant, pipelined
// ----------------------------------------------------------------------------
// channel   ports                               handshake
// request   start, busy, a_c0r0 .. a_c2r2       start & !busy
// result    done, r_c0r0 .. r_c2r2, flags       done, one cycle
// config    cfg_we, cfg_wdata                   cfg_we
//
// a request can enter every cycle; busy stays low
// a result passes through 2 cofactor stages, 5 determinant stages,
// 34 divider stages (an overflow check, then one quotient bit each), 1 output
// reset clears valid bits and sets the threshold to its default
// the result side cannot stall, so nothing in the pipe ever waits
// ----------------------------------------------------------------------------
`include "matrix3x3_inverse_assert.svh"

module matrix3x3_inverse
    import mi3_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  logic signed [31:0] a_c0r0,
    input  logic signed [31:0] a_c0r1,
    input  logic signed [31:0] a_c0r2,
    input  logic signed [31:0] a_c1r0,
    input  logic signed [31:0] a_c1r1,
    input  logic signed [31:0] a_c1r2,
    input  logic signed [31:0] a_c2r0,
    input  logic signed [31:0] a_c2r1,
    input  logic signed [31:0] a_c2r2,
    input  logic          cfg_we,
    input  logic [62:0]   cfg_wdata,
    output logic          done,
    output logic signed [31:0] r_c0r0,
    output logic signed [31:0] r_c0r1,
    output logic signed [31:0] r_c0r2,
    output logic signed [31:0] r_c1r0,
    output logic signed [31:0] r_c1r1,
    output logic signed [31:0] r_c1r2,
    output logic signed [31:0] r_c2r0,
    output logic signed [31:0] r_c2r1,
    output logic signed [31:0] r_c2r2,
    output logic          singular,
    output logic          saturated
);

    thr_t      thr_reg;
    entry_t    e [9];
    logic      cf_valid;
    cof_t      cf [9];
    entry_t    erow [3];
    det_info_t info;
    dmag_t     dmag;
    cmag_t     cmag [9];
    logic      cneg [9];
    logic [31:0] lane_val [9];
    logic        lane_sat [9];
    logic        sv_reg [DIV_STAGES];
    logic        ss_reg [DIV_STAGES];
    logic        done_reg;
    logic        sing_reg;
    logic        sat_reg;
    logic [31:0] res_reg [9];
    logic        any_sat;

    assign busy = 1'b0;

    assign e[0] = a_c0r0;
    assign e[1] = a_c0r1;
    assign e[2] = a_c0r2;
    assign e[3] = a_c1r0;
    assign e[4] = a_c1r1;
    assign e[5] = a_c1r2;
    assign e[6] = a_c2r0;
    assign e[7] = a_c2r1;
    assign e[8] = a_c2r2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
        end
        else if (cfg_we)
        begin
            thr_reg <= cfg_wdata;
        end
    end

    mi3_cof u_cof (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start & ~busy),
        .e        (e),
        .cf_valid (cf_valid),
        .cf       (cf),
        .erow     (erow)
    );

    mi3_det u_det (
        .clk       (clk),
        .rst_n     (rst_n),
        .cf_valid  (cf_valid),
        .cf        (cf),
        .erow      (erow),
        .threshold (thr_reg),
        .info      (info),
        .dmag      (dmag),
        .cmag      (cmag),
        .cneg      (cneg)
    );

    for (genvar k = 0; k < 9; k++)
    begin : g_lane
        mi3_div u_div (
            .clk  (clk),
            .num  ({cmag[k], 32'b0}),
            .den  (dmag),
            .negq (cneg[k] ^ info.neg),
            .val  (lane_val[k]),
            .sat  (lane_sat[k])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < DIV_STAGES; s++)
            begin
                sv_reg[s] <= 1'b0;
            end
            done_reg <= 1'b0;
        end
        else
        begin
            sv_reg[0] <= info.valid;
            for (int s = 1; s < DIV_STAGES; s++)
            begin
                sv_reg[s] <= sv_reg[s-1];
            end
            done_reg <= sv_reg[DIV_STAGES-1];
        end
    end

    always_comb
    begin
        any_sat = 1'b0;
        for (int k = 0; k < 9; k++)
        begin
            any_sat = any_sat | lane_sat[k];
        end
    end

    always_ff @(posedge clk)
    begin
        ss_reg[0] <= info.sing;
        for (int s = 1; s < DIV_STAGES; s++)
        begin
            ss_reg[s] <= ss_reg[s-1];
        end
        sing_reg <= ss_reg[DIV_STAGES-1];
        sat_reg  <= ~ss_reg[DIV_STAGES-1] & any_sat;
        for (int k = 0; k < 9; k++)
        begin
            if (ss_reg[DIV_STAGES-1])
            begin
                // identity on a singular matrix
                res_reg[k] <= (k == 0 || k == 4 || k == 8) ? Q_ONE : '0;
            end
            else
            begin
                res_reg[k] <= lane_val[k];
            end
        end
    end

    assign done      = done_reg;
    assign singular  = sing_reg;
    assign saturated = sat_reg;
    assign r_c0r0    = res_reg[0];
    assign r_c0r1    = res_reg[1];
    assign r_c0r2    = res_reg[2];
    assign r_c1r0    = res_reg[3];
    assign r_c1r1    = res_reg[4];
    assign r_c1r2    = res_reg[5];
    assign r_c2r0    = res_reg[6];
    assign r_c2r1    = res_reg[7];
    assign r_c2r2    = res_reg[8];

    `MI3_ASSERT_IMP(a_sing_no_sat, done && singular, !saturated)
    `MI3_ASSERT_IMP(a_sing_identity, done && singular, r_c0r0 == Q_ONE && r_c1r1 == Q_ONE && r_c2r2 == Q_ONE && r_c1r0 == 32'sd0)
    `MI3_ASSERT_NEXT(a_done_follows, sv_reg[DIV_STAGES-1], done)

endmodule

FILE: design/mi3_cof.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_cof
// two-stage cofactor unit: eighteen products, then nine exact differences
// ----------------------------------------------------------------------------
module mi3_cof
    import mi3_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    input  entry_t e [9],
    output logic   cf_valid,
    output cof_t   cf [9],
    output entry_t erow [3]
);

    prod_t  pa_reg [9];
    prod_t  pb_reg [9];
    entry_t e1_reg [3];
    entry_t e2_reg [3];
    cof_t   cf_reg [9];
    logic   v1_reg;
    logic   v2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 9; k++)
        begin
            pa_reg[k] <= e[CF_IDX[k][0]] * e[CF_IDX[k][1]];
            pb_reg[k] <= e[CF_IDX[k][2]] * e[CF_IDX[k][3]];
            cf_reg[k] <= cof_t'(pa_reg[k]) - cof_t'(pb_reg[k]);
        end
        for (int j = 0; j < 3; j++)
        begin
            e1_reg[j] <= e[j * 3];
            e2_reg[j] <= e1_reg[j];
        end
    end

    assign cf_valid = v2_reg;
    assign cf       = cf_reg;
    assign erow     = e2_reg;

endmodule

FILE: design/mi3_det.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_det
// determinant by first-row expansion, magnitude and singular test
// five stages: split products, term, sum, magnitude, threshold compare
// ----------------------------------------------------------------------------
module mi3_det
    import mi3_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cf_valid,
    input  cof_t      cf [9],
    input  entry_t    erow [3],
    input  thr_t      threshold,
    output det_info_t info,
    output dmag_t     dmag,
    output cmag_t     cmag [9],
    output logic      cneg [9]
);

    logic        [63:0] pl_reg [3];
    logic        [63:0] ph_reg [3];
    logic               tn_reg [3];
    det_t               term_reg [3];
    det_t               dsum_reg;
    dmag_t              dm_reg;
    logic               dneg_reg;
    dmag_t              dm7_reg;
    logic               dneg7_reg;
    logic               sing_reg;
    cmag_t              cm_reg [5][9];
    logic               cn_reg [5][9];
    logic         [4:0] v_reg;

    cmag_t              cabs [9];
    logic        [31:0] emag [3];
    logic        [95:0] tmag [3];
    det_t               dabs;

    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            cabs[k] = cf[k][64] ? cmag_t'(-cf[k]) : cmag_t'(cf[k]);
        end
        for (int j = 0; j < 3; j++)
        begin
            emag[j] = erow[j][31] ? 32'(-erow[j]) : 32'(erow[j]);
            tmag[j] = {32'b0, pl_reg[j]} + {ph_reg[j], 32'b0};
        end
        dabs = dsum_reg[97] ? -dsum_reg : dsum_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[3:0], cf_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 3; j++)
        begin
            // 64 x 32 split into two 32 x 32 partial products
            pl_reg[j]   <= {32'b0, cabs[j][31:0]} * {32'b0, emag[j]};
            ph_reg[j]   <= {32'b0, cabs[j][63:32]} * {32'b0, emag[j]};
            tn_reg[j]   <= erow[j][31] ^ cf[j][64];
            term_reg[j] <= tn_reg[j] ? -det_t'({2'b0, tmag[j]}) : det_t'({2'b0, tmag[j]});
        end
        dsum_reg  <= term_reg[0] + term_reg[1] + term_reg[2];
        dm_reg    <= dabs[95:0];
        dneg_reg  <= dsum_reg[97];
        dm7_reg   <= dm_reg;
        dneg7_reg <= dneg_reg;
        // zero is always singular, even with a zero threshold
        sing_reg  <= (dm_reg == '0) ||
                     (dm_reg[95:64] == '0 && dm_reg[63:0] < {1'b0, threshold});
        for (int k = 0; k < 9; k++)
        begin
            cm_reg[0][k] <= cabs[k];
            cn_reg[0][k] <= cf[k][64];
            for (int s = 1; s < 5; s++)
            begin
                cm_reg[s][k] <= cm_reg[s-1][k];
                cn_reg[s][k] <= cn_reg[s-1][k];
            end
        end
    end

    assign info.valid = v_reg[4];
    assign info.sing  = sing_reg;
    assign info.neg   = dneg7_reg;
    assign dmag       = dm7_reg;
    assign cmag       = cm_reg[4];
    assign cneg       = cn_reg[4];

endmodule

FILE: design/mi3_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_div
// one divider lane: overflow check, then one restoring quotient bit per stage,
// truncation toward zero and saturation to q16.16
// ----------------------------------------------------------------------------
module mi3_div
    import mi3_pkg::*;
(
    input  logic        clk,
    input  dmag_t       num,
    input  dmag_t       den,
    input  logic        negq,
    output logic [31:0] val,
    output logic        sat
);

    dmag_t rem_reg [DIV_STAGES];
    quot_t q_reg   [DIV_STAGES];
    dmag_t den_reg [DIV_STAGES];
    logic  neg_reg [DIV_STAGES];
    logic  ovf_reg [DIV_STAGES];

    always_ff @(posedge clk)
    begin
        // quotient of 2^33 or more always saturates
        rem_reg[0] <= num;
        q_reg[0]   <= '0;
        den_reg[0] <= den;
        neg_reg[0] <= negq;
        ovf_reg[0] <= {33'b0, num} >= {den, 33'b0};
    end

    for (genvar s = 1; s < DIV_STAGES; s++)
    begin : g_stage
        localparam int B = DIV_STAGES - 1 - s;
        logic [128:0] dsh;
        logic         ge;

        assign dsh = {33'b0, den_reg[s-1]} << B;
        assign ge  = {33'b0, rem_reg[s-1]} >= dsh;

        always_ff @(posedge clk)
        begin
            rem_reg[s] <= ge ? rem_reg[s-1] - dsh[95:0] : rem_reg[s-1];
            q_reg[s]   <= {q_reg[s-1][QBITS-2:0], ge};
            den_reg[s] <= den_reg[s-1];
            neg_reg[s] <= neg_reg[s-1];
            ovf_reg[s] <= ovf_reg[s-1];
        end
    end

    quot_t qf;
    quot_t qneg;

    always_comb
    begin
        qf   = q_reg[DIV_STAGES-1];
        qneg = -qf;
        if (neg_reg[DIV_STAGES-1])
        begin
            sat = ovf_reg[DIV_STAGES-1] || qf > {1'b0, SAT_NEG};
            val = sat ? SAT_NEG : qneg[31:0];
        end
        else
        begin
            sat = ovf_reg[DIV_STAGES-1] || qf > {1'b0, SAT_POS};
            val = sat ? SAT_POS : qf[31:0];
        end
    end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the 3x3 q16.16 matrix inverse: a queue-fed driver
// sends requests with random idle bursts, an exact-width predictor works out
// each inverse, and a monitor checks every result field against it, across
// several singular thresholds written while the pipe is empty
// ----------------------------------------------------------------------------
module tb_top;
    import mi3_pkg::*;

    localparam int  DRAIN_CYCLES = 60;
    localparam int  CYCLE_LIMIT  = 400000;

    typedef struct {
        entry_t m [9];
    } matrix_t;

    typedef struct {
        logic [31:0] r [9];
        logic        sing;
        logic        sat;
    } inverse_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start;
    logic        busy;
    entry_t      in_e [9];
    logic        cfg_we;
    thr_t        cfg_wdata;
    logic        done;
    entry_t      out_e [9];
    logic        singular;
    logic        saturated;

    matrix_t     pending_q [$];
    inverse_t    inverse_q [$];
    thr_t        thr_model = THR_RESET;
    bit          no_idle = 1'b0;
    int          gap_cnt;
    int          cycle_cnt = 0;
    int          mismatches = 0;
    int          results_seen = 0;
    int          sing_seen = 0;
    int          sat_seen = 0;

    always #2 clk = ~clk;

    matrix3x3_inverse u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .a_c0r0    (in_e[0]),
        .a_c0r1    (in_e[1]),
        .a_c0r2    (in_e[2]),
        .a_c1r0    (in_e[3]),
        .a_c1r1    (in_e[4]),
        .a_c1r2    (in_e[5]),
        .a_c2r0    (in_e[6]),
        .a_c2r1    (in_e[7]),
        .a_c2r2    (in_e[8]),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .done      (done),
        .r_c0r0    (out_e[0]),
        .r_c0r1    (out_e[1]),
        .r_c0r2    (out_e[2]),
        .r_c1r0    (out_e[3]),
        .r_c1r1    (out_e[4]),
        .r_c1r2    (out_e[5]),
        .r_c2r0    (out_e[6]),
        .r_c2r1    (out_e[7]),
        .r_c2r2    (out_e[8]),
        .singular  (singular),
        .saturated (saturated)
    );

    // exact adjugate over determinant, quotients truncated and clamped
    function automatic inverse_t predict_inverse(input entry_t m [9], input thr_t thr);
        inverse_t            res;
        logic signed [64:0]  cf [9];
        logic signed [97:0]  det;
        logic        [97:0]  dmag;
        logic        [64:0]  cmag;
        logic        [127:0] num;
        logic        [127:0] q;
        logic                neg;
        for (int k = 0; k < 9; k++)
        begin
            cf[k] = m[CF_IDX[k][0]] * m[CF_IDX[k][1]] - m[CF_IDX[k][2]] * m[CF_IDX[k][3]];
        end
        det = m[0] * cf[0] + m[3] * cf[1] + m[6] * cf[2];
        dmag = det[97] ? -det : det;
        res.sing = (dmag == 0) || (dmag < {35'd0, thr});
        res.sat = 1'b0;
        for (int k = 0; k < 9; k++)
        begin
            if (res.sing)
            begin
                res.r[k] = (k == 0 || k == 4 || k == 8) ? Q_ONE : 32'd0;
            end
            else
            begin
                cmag = cf[k][64] ? -cf[k] : cf[k];
                num = {31'd0, cmag, 32'd0};
                q = num / {30'd0, dmag};
                neg = cf[k][64] != det[97];
                if (neg && q > 128'h8000_0000)
                begin
                    res.r[k] = SAT_NEG;
                    res.sat = 1'b1;
                end
                else if (!neg && q > 128'h7fff_ffff)
                begin
                    res.r[k] = SAT_POS;
                    res.sat = 1'b1;
                end
                else
                begin
                    res.r[k] = neg ? -q[31:0] : q[31:0];
                end
            end
        end
        return res;
    endfunction

    // request driver, with random idle bursts between requests
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            gap_cnt <= 0;
            for (int k = 0; k < 9; k++)
                in_e[k] <= '0;
        end
        else
        begin
            if (start && !busy)
                inverse_q.push_back(predict_inverse(in_e, thr_model));
            if (!start || !busy)
            begin
                if (gap_cnt > 0)
                begin
                    gap_cnt <= gap_cnt - 1;
                    start <= 1'b0;
                end
                else if (pending_q.size() > 0)
                begin
                    if (!no_idle && $urandom_range(0, 9) == 0)
                    begin
                        gap_cnt <= $urandom_range(0, 7);
                        start <= 1'b0;
                    end
                    else
                    begin
                        matrix_t nx;
                        nx = pending_q.pop_front();
                        for (int k = 0; k < 9; k++)
                            in_e[k] <= nx.m[k];
                        start <= 1'b1;
                    end
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            inverse_t exp_r;
            bit       bad;
            bad = 1'b0;
            if (inverse_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result at cycle %0d", cycle_cnt);
            end
            else
            begin
                exp_r = inverse_q.pop_front();
                results_seen++;
                if (exp_r.sing) sing_seen++;
                if (exp_r.sat) sat_seen++;
                for (int k = 0; k < 9; k++)
                begin
                    if (out_e[k] !== exp_r.r[k])
                    begin
                        bad = 1'b1;
                        if (mismatches < 10)
                            $display("entry %0d: expected %h got %h", k, exp_r.r[k], out_e[k]);
                    end
                end
                if (singular !== exp_r.sing || saturated !== exp_r.sat)
                begin
                    bad = 1'b1;
                    if (mismatches < 10)
                        $display("flags sing/sat: expected %b%b got %b%b",
                                 exp_r.sing, exp_r.sat, singular, saturated);
                end
                if (bad)
                    mismatches++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic entry_t rand_entry(input int mode);
        case (mode)
            0: return $urandom;
            1: return $signed($urandom_range(0, 1 << 19)) - (1 << 18);
            2: return $signed($urandom_range(0, 512)) - 256;
            default: return $signed($urandom_range(0, 1 << 23)) - (1 << 22);
        endcase
    endfunction

    function automatic matrix_t rand_matrix();
        matrix_t mx;
        int      mode;
        mode = $urandom_range(0, 3);
        for (int k = 0; k < 9; k++)
            mx.m[k] = rand_entry(mode);
        case ($urandom_range(0, 9))
            // dependent third column, determinant exactly zero unless a sum wraps
            0: for (int k = 0; k < 3; k++) mx.m[6 + k] = mx.m[k] + mx.m[3 + k];
            // diagonal entries raised by 4.0 in q16.16
            1, 2: for (int k = 0; k < 9; k += 4) mx.m[k] = mx.m[k] + 32'sh0004_0000;
            default: ;
        endcase
        return mx;
    endfunction

    function automatic matrix_t diag_matrix(input entry_t d0, input entry_t d1,
                                            input entry_t d2, input entry_t off);
        matrix_t mx;
        for (int k = 0; k < 9; k++)
            mx.m[k] = off;
        mx.m[0] = d0;
        mx.m[4] = d1;
        mx.m[8] = d2;
        return mx;
    endfunction

    task automatic run_batch(input int n);
        for (int i = 0; i < n; i++)
            pending_q.push_back(rand_matrix());
        wait (pending_q.size() == 0 && !start);
        wait (inverse_q.size() == 0);
    endtask

    task automatic write_threshold(input thr_t val);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_wdata <= val;
        cfg_we <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
        thr_model = val;
    endtask

    initial
    begin
        matrix_t mx;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed requests
        pending_q.push_back(diag_matrix(Q_ONE, Q_ONE, Q_ONE, 0));
        pending_q.push_back(diag_matrix(0, 0, 0, 0));
        pending_q.push_back(diag_matrix(SAT_NEG, SAT_NEG, SAT_NEG, SAT_NEG));
        pending_q.push_back(diag_matrix(SAT_POS, SAT_POS, SAT_POS, SAT_POS));
        pending_q.push_back(diag_matrix(SAT_NEG, SAT_POS, SAT_NEG, 0));
        pending_q.push_back(diag_matrix(SAT_POS, SAT_NEG, SAT_POS, 1));
        pending_q.push_back(diag_matrix(32'sh0002_0000, 32'sh0004_0000, -32'sh0008_0000, 0));
        pending_q.push_back(diag_matrix(1, 1, 1, 0));            // singular, tiny det
        pending_q.push_back(diag_matrix(32'sh100, 32'sh100, 32'sh100, 0));
        pending_q.push_back(diag_matrix(32'sh400, 32'sh400, 32'sh400, 0)); // large inverse
        pending_q.push_back(diag_matrix(-32'sh400, 32'sh400, 32'sh400, 0));
        pending_q.push_back(diag_matrix(SAT_NEG, 1, 1, 0));
        pending_q.push_back(diag_matrix(32'sh0001_0000, -32'sh0001_0000, 32'sh0000_8000, 7));
        mx = diag_matrix(Q_ONE, Q_ONE, Q_ONE, 0);
        mx.m[6] = 32'sh0003_0000;
        mx.m[7] = -32'sh0002_0000;                              // affine-like form
        pending_q.push_back(mx);
        run_batch(130);

        write_threshold('0);
        pending_q.push_back(diag_matrix(1, 1, 1, 0));
        pending_q.push_back(diag_matrix(0, Q_ONE, Q_ONE, 0));   // zero det stays singular
        run_batch(130);

        write_threshold({63{1'b1}});
        pending_q.push_back(diag_matrix(SAT_NEG, SAT_NEG, SAT_NEG, 0));
        run_batch(130);

        write_threshold(63'd1 << 40);
        pending_q.push_back(diag_matrix(Q_ONE, Q_ONE, 32'sh100, 0)); // det at threshold
        pending_q.push_back(diag_matrix(Q_ONE, Q_ONE, 32'sh0ff, 0)); // just below
        run_batch(130);

        write_threshold(THR_RESET);
        no_idle = 1'b1;
        run_batch(180);

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("checked %0d inverses (%0d singular, %0d clamped) over five thresholds",
                 results_seen, sing_seen, sat_seen);
        $display("mismatching results: %0d", mismatches);
        if (mismatches == 0 && inverse_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: files.f
+incdir+design
design/mi3_pkg.sv
design/mi3_cof.sv
design/mi3_det.sv
design/mi3_div.sv
design/matrix3x3_inverse.sv
bench/tb_top.sv
